>>> rtl/assert_macros.svh
// Assertion helpers used by the round key schedule module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check an implication whose consequent holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/aks_pkg.sv
package aks_pkg;

  localparam int ROUND_KEY_COUNT = 11;
  localparam int RK_ADDR_W = 4;
  localparam int RND_W = 4;

  typedef logic [RND_W-1:0] rnd_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_EXPAND = 4'b0010,
    ST_EMIT   = 4'b0100,
    ST_DRAIN  = 4'b1000
  } state_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[x];
  endfunction

  function automatic logic [7:0] rcon(input rnd_t r);
    logic [7:0] v;
    case (r)
      4'd1:    v = 8'h01;
      4'd2:    v = 8'h02;
      4'd3:    v = 8'h04;
      4'd4:    v = 8'h08;
      4'd5:    v = 8'h10;
      4'd6:    v = 8'h20;
      4'd7:    v = 8'h40;
      4'd8:    v = 8'h80;
      4'd9:    v = 8'h1b;
      4'd10:   v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
    logic [7:0] a2, a4, a8, acc;
    a2 = xt(a);
    a4 = xt(a2);
    a8 = xt(a4);
    acc = (b[0] ? a : 8'h00) ^ (b[1] ? a2 : 8'h00) ^ (b[2] ? a4 : 8'h00)
        ^ (b[3] ? a8 : 8'h00);
    return acc;
  endfunction

  function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
    logic [7:0] b0, b1, b2, b3;
    b0 = c[31:24];
    b1 = c[23:16];
    b2 = c[15:8];
    b3 = c[7:0];
    return {gmul(b0, 4'hE) ^ gmul(b1, 4'hB) ^ gmul(b2, 4'hD) ^ gmul(b3, 4'h9),
            gmul(b0, 4'h9) ^ gmul(b1, 4'hE) ^ gmul(b2, 4'hB) ^ gmul(b3, 4'hD),
            gmul(b0, 4'hD) ^ gmul(b1, 4'h9) ^ gmul(b2, 4'hE) ^ gmul(b3, 4'hB),
            gmul(b0, 4'hB) ^ gmul(b1, 4'hD) ^ gmul(b2, 4'h9) ^ gmul(b3, 4'hE)};
  endfunction

  function automatic logic [63:0] inv_mix_half(input logic [63:0] h);
    return {inv_mix_col(h[63:32]), inv_mix_col(h[31:0])};
  endfunction

endpackage

>>> rtl/aes128_round_key_schedule.sv
// AES-128 round key schedule.
// Input channel: in_valid/in_stall carry a command (0 = encryption order,
// 1 = decryption order) and the key as two 64-bit halves. A transfer takes
// place on a clock edge with in_valid high and in_stall low.
// Result channel: out_valid/out_stall carry eleven round keys per key, with
// out_round_index counting 0..10 and out_last_key on the eleventh.
// The key is expanded into a round key memory, one round per cycle (one row
// write each, eleven rows), then the rows are read back through the single
// registered read port. With no stall the results follow one per cycle; the
// next key is accepted only after all eleven results have left the output.
// Decryption order reads rows 10 down to 0 and applies InvMixColumns to the
// nine middle keys on the way out.
// Reset (rst_n low, synchronous) returns the control to idle and drops any
// pending results; the memory content is left as is.
// With out_valid and out_stall high the output register holds and one row
// read meanwhile waits in a skid; no read issues while it fills or is full.
module aes128_round_key_schedule
  import aks_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [63:0] in_key_high,
  input  logic [63:0] in_key_low,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_round_index,
  output logic [63:0] out_round_key_high,
  output logic [63:0] out_round_key_low,
  output logic        out_last_key
);
`include "assert_macros.svh"

  localparam rnd_t LAST = rnd_t'(ROUND_KEY_COUNT - 1);

  state_t state_r, state_nxt;
  rnd_t   cnt_r, cnt_nxt;         // expansion round or emit position
  logic   dec_r;
  logic [127:0] work_r;           // running key words

  logic         wr_en;
  logic [RK_ADDR_W-1:0] wr_addr, rd_addr;
  logic [127:0] wr_data, rd_data;

  // read pipeline: rd_v_r marks rd_data valid in the same cycle
  logic   rd_v_r;
  rnd_t   rd_idx_r;
  // skid for a row that arrives while the output is stalled
  logic   sk_v_r;
  logic [127:0] sk_d_r;
  rnd_t   sk_idx_r;

  logic   out_v_r;
  rnd_t   out_idx_r;
  logic [127:0] out_d_r;

  // one expansion round
  logic [31:0] w0, w1, w2, w3, t;
  always_comb begin
    t  = {sbox(work_r[23:16]), sbox(work_r[15:8]), sbox(work_r[7:0]),
          sbox(work_r[31:24])} ^ {rcon(cnt_r), 24'h0};
    w0 = work_r[127:96] ^ t;
    w1 = work_r[95:64] ^ w0;
    w2 = work_r[63:32] ^ w1;
    w3 = work_r[31:0] ^ w2;
  end

  assign in_stall = (state_r != ST_IDLE);

  logic can_issue;
  assign can_issue = (state_r == ST_EMIT) && !sk_v_r && !(rd_v_r && out_v_r && out_stall);

  always_comb begin
    wr_en = 1'b0;
    wr_data = {w0, w1, w2, w3};
    wr_addr = RK_ADDR_W'(cnt_r);
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXPAND;
          cnt_nxt = rnd_t'(0);
        end
      end
      ST_EXPAND: begin
        wr_en = 1'b1;
        if (cnt_r == rnd_t'(0)) wr_data = work_r;
        if (cnt_r == LAST) begin
          state_nxt = ST_EMIT;
          cnt_nxt = rnd_t'(0);
        end else begin
          cnt_nxt = cnt_r + rnd_t'(1);
        end
      end
      ST_EMIT: begin
        if (can_issue) begin
          if (cnt_r == LAST) state_nxt = ST_DRAIN;
          else cnt_nxt = cnt_r + rnd_t'(1);
        end
      end
      ST_DRAIN: begin
        if (!rd_v_r && !sk_v_r && !(out_v_r && !out_stall) && !out_v_r) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign rd_addr = RK_ADDR_W'(dec_r ? (LAST - cnt_r) : cnt_r);

  aks_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // transform a stored row for emit position idx
  function automatic logic [127:0] shape(input logic [127:0] d, input rnd_t idx,
                                         input logic dec);
    logic [127:0] r;
    r = d;
    if (dec && idx != rnd_t'(0) && idx != LAST) begin
      r = {inv_mix_half(d[127:64]), inv_mix_half(d[63:0])};
    end
    return r;
  endfunction

  logic out_free;
  assign out_free = !out_v_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= rnd_t'(0);
      rd_v_r  <= 1'b0;
      sk_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      rd_v_r  <= can_issue;
      // advance output: skid first, then fresh read data
      if (out_free) begin
        if (sk_v_r) begin
          out_v_r <= 1'b1;
          sk_v_r  <= rd_v_r;
        end else begin
          out_v_r <= rd_v_r;
        end
      end else if (rd_v_r) begin
        sk_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      work_r <= {in_key_high, in_key_low};
      dec_r  <= in_command;
    end else if (state_r == ST_EXPAND && cnt_r != rnd_t'(0)) begin
      work_r <= {w0, w1, w2, w3};
    end else if (state_r == ST_EXPAND) begin
      work_r <= work_r;
    end
    if (can_issue) rd_idx_r <= cnt_r;
    if (out_free) begin
      if (sk_v_r) begin
        out_d_r <= sk_d_r;
        out_idx_r <= sk_idx_r;
        sk_d_r <= shape(rd_data, rd_idx_r, dec_r);
        sk_idx_r <= rd_idx_r;
      end else begin
        out_d_r <= shape(rd_data, rd_idx_r, dec_r);
        out_idx_r <= rd_idx_r;
      end
    end else if (rd_v_r) begin
      sk_d_r <= shape(rd_data, rd_idx_r, dec_r);
      sk_idx_r <= rd_idx_r;
    end
  end

  assign out_valid          = out_v_r;
  assign out_round_index    = out_idx_r;
  assign out_round_key_high = out_d_r[127:64];
  assign out_round_key_low  = out_d_r[63:0];
  assign out_last_key       = (out_idx_r == LAST);

  `ASSERT_IMPL(a_no_issue_when_skid, clk, rst_n, sk_v_r, !can_issue,
               "read issued while skid full")
  `ASSERT_NEXT(a_hold_stalled, clk, rst_n, out_v_r && out_stall,
               out_v_r && $stable(out_idx_r), "stalled result changed")
  `ASSERT_IMPL(a_busy_no_accept, clk, rst_n, state_r != ST_IDLE, in_stall,
               "input accepted while busy")

endmodule

>>> rtl/aks_store.sv
module aks_store
  import aks_pkg::*;
(
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [RK_ADDR_W-1:0] wr_addr,
  input  logic [127:0]         wr_data,
  input  logic [RK_ADDR_W-1:0] rd_addr,
  output logic [127:0]         rd_data
);

  // Two 64-bit halves per round key, written and read as one row.
  logic [127:0] mem [ROUND_KEY_COUNT];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
